/* hdl/fat_relative_path_validator_assert.svh */
// Assertion macros for the checker file of the path validator.
// No dependencies; included by bare file name.
`ifndef FAT_RELATIVE_PATH_VALIDATOR_ASSERT_SVH
`define FAT_RELATIVE_PATH_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRPV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRPV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/frpv_pkg.sv */
// Package for the relative path validator: status codes, character
// constants and the component check function. No dependencies.
package frpv_pkg;

    typedef logic [3:0][7:0] head_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_ARG  = 2'd1;
    localparam logic [1:0] STATUS_BAD_PATH = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Reserved device stems, lower case, first character in the top byte
    localparam logic [23:0] WORD_CON = 24'h636f6e;
    localparam logic [23:0] WORD_PRN = 24'h70726e;
    localparam logic [23:0] WORD_AUX = 24'h617578;
    localparam logic [23:0] WORD_NUL = 24'h6e756c;
    localparam logic [23:0] WORD_COM = 24'h636f6d;
    localparam logic [23:0] WORD_LPT = 24'h6c7074;

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    endfunction

    function automatic logic head_is(head_t head, logic [23:0] word);
        return (to_lower(head[0]) == word[23:16]) &&
               (to_lower(head[1]) == word[15:8]) &&
               (to_lower(head[2]) == word[7:0]);
    endfunction

    function automatic logic forbidden_byte(logic [7:0] c);
        return c < 8'h20 || c > 8'h7e || c == 8'h22 || c == 8'h2a || c == 8'h3a ||
               c == 8'h3c || c == 8'h3e || c == 8'h3f || c == 8'h5c || c == 8'h7c;
    endfunction

    // True when the component being closed breaks a naming rule.
    function automatic logic component_bad(logic [8:0] len, head_t head, logic [2:0] stem,
                                           logic [7:0] last_char, logic [8:0] limit);
        logic reserved;
        logic bad;
        reserved = 1'b0;
        if (stem == 3'd3) begin
            reserved = head_is(head, WORD_CON) || head_is(head, WORD_PRN) ||
                       head_is(head, WORD_AUX) || head_is(head, WORD_NUL);
        end else if (stem == 3'd4) begin
            reserved = (head_is(head, WORD_COM) || head_is(head, WORD_LPT)) &&
                       head[3] >= CH_ONE && head[3] <= CH_NINE;
        end
        if (len == 9'd0) begin
            bad = 1'b1;
        end else begin
            bad = (len > limit) || last_char == CH_SPACE || last_char == CH_DOT ||
                  (len == 9'd1 && head[0] == CH_DOT) ||
                  (len == 9'd2 && head[0] == CH_DOT && head[1] == CH_DOT) ||
                  reserved;
        end
        return bad;
    endfunction

endpackage

/* hdl/fat_relative_path_validator.sv */
// Relative path validator for long file names, top level.
// Depends on frpv_pkg.
//
// Usage:
//   Input stream s_axis_*: one path byte per beat in tdata[7:0]; tlast marks
//   the final byte; tuser[0] set means the beat stands for an empty path
//   (tdata and tlast are then ignored, a status still follows).
//   Output stream m_axis_*: one status beat per path, tdata[1:0]:
//   0 ok, 1 limit register is zero, 2 invalid path, 3 path too long.
//   cfg_wr_en/cfg_wr_data write the path byte limit; write only while idle.
// Timing:
//   A byte is registered on acceptance and folded into the path state as it
//   leaves the input register; a last or empty beat then also loads the status
//   beat. One beat per cycle is sustained, but for the stall below: the per-byte update is a
//   single level of counters and compares between the input register and
//   the state/result registers.
// Reset: aresetn (synchronous, active low) drops both valid flags, clears
//   the path state but for head_reg and loads the limit with MAX_PATH_BYTES.
// Stall: a held status beat stops only a following last/empty beat in the
//   input register; other bytes keep flowing into the path state.
module fat_relative_path_validator
    import frpv_pkg::*;
#(
    parameter int MAX_PATH_BYTES  = 4096,
    parameter int COMPONENT_LIMIT = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] path_byte
    input  logic        s_axis_tlast,
    input  logic [0:0]  s_axis_tuser,   // [0] empty_path
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] status, [7:2] zero
);

    localparam logic [8:0]  COMP_LIMIT = 9'(COMPONENT_LIMIT);
    localparam logic [12:0] LIMIT_RESET = 13'(MAX_PATH_BYTES);

    logic [12:0] max_len_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_empty_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;

    logic [13:0] byte_count_reg,  byte_count_next;
    logic [8:0]  comp_len_reg,    comp_len_next;
    logic [2:0]  stem_len_reg,    stem_len_next;
    logic        dot_seen_reg,    dot_seen_next;
    logic [7:0]  prev_byte_reg,   prev_byte_next;
    logic        invalid_reg,     invalid_next;
    head_t       head_reg,        head_next;
    logic [1:0]  status_next;

    // Values after the current byte, before any end-of-path close
    logic [13:0] cap;
    logic [13:0] bc1;
    logic [8:0]  cl1;
    logic [2:0]  sl1;
    logic        dot1;
    logic        inv1;
    logic        inv2;
    head_t       head1;

    logic produces;
    logic advance;

    assign produces      = in_last_reg || in_empty_reg;
    assign advance       = in_valid_reg && (!produces || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_status_reg};

    always_comb begin
        cap   = {1'b0, max_len_reg} + 14'd1;
        bc1   = (byte_count_reg < cap) ? byte_count_reg + 14'd1 : byte_count_reg;
        head1 = head_reg;
        if (in_byte_reg == CH_SLASH) begin
            inv1 = invalid_reg ||
                   component_bad(comp_len_reg, head_reg, stem_len_reg, prev_byte_reg, COMP_LIMIT);
            cl1  = 9'd0;
            sl1  = 3'd0;
            dot1 = 1'b0;
        end else begin
            inv1 = invalid_reg || forbidden_byte(in_byte_reg) ||
                   (comp_len_reg == 9'd0 && in_byte_reg == CH_SPACE);
            if (comp_len_reg < 9'd4) begin
                head1[comp_len_reg[1:0]] = in_byte_reg;
            end
            dot1 = dot_seen_reg || (in_byte_reg == CH_DOT);
            sl1  = (in_byte_reg != CH_DOT && !dot_seen_reg && stem_len_reg < 3'd5)
                   ? stem_len_reg + 3'd1 : stem_len_reg;
            cl1  = (comp_len_reg < 9'd256) ? comp_len_reg + 9'd1 : comp_len_reg;
        end
        inv2 = inv1 || component_bad(cl1, head1, sl1, in_byte_reg, COMP_LIMIT);

        if (in_empty_reg) begin
            status_next = (max_len_reg == 13'd0) ? STATUS_BAD_ARG : STATUS_BAD_PATH;
        end else if (max_len_reg == 13'd0) begin
            status_next = STATUS_BAD_ARG;
        end else if (bc1 > {1'b0, max_len_reg}) begin
            status_next = STATUS_TOO_LONG;
        end else if (inv2) begin
            status_next = STATUS_BAD_PATH;
        end else begin
            status_next = STATUS_OK;
        end

        head_next = head1;
        if (produces) begin
            byte_count_next = 14'd0;
            comp_len_next   = 9'd0;
            stem_len_next   = 3'd0;
            dot_seen_next   = 1'b0;
            prev_byte_next  = 8'd0;
            invalid_next    = 1'b0;
        end else begin
            byte_count_next = bc1;
            comp_len_next   = cl1;
            stem_len_next   = sl1;
            dot_seen_next   = dot1;
            prev_byte_next  = in_byte_reg;
            invalid_next    = inv1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= LIMIT_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_count_reg <= 14'd0;
            comp_len_reg   <= 9'd0;
            stem_len_reg   <= 3'd0;
            dot_seen_reg   <= 1'b0;
            prev_byte_reg  <= 8'd0;
            invalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                byte_count_reg <= byte_count_next;
                comp_len_reg   <= comp_len_next;
                stem_len_reg   <= stem_len_next;
                dot_seen_reg   <= dot_seen_next;
                prev_byte_reg  <= prev_byte_next;
                invalid_reg    <= invalid_next;
            end
            if (advance && produces) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser[0];
        end
        if (advance) begin
            head_reg <= head_next;
        end
        if (advance && produces) begin
            out_status_reg <= status_next;
        end
    end

endmodule

/* hdl/frpv_checker.sv */
// Port-level checker for the relative path validator, bound to the top level.
// Depends on fat_relative_path_validator_assert.svh.
`include "fat_relative_path_validator_assert.svh"

module frpv_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic [0:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A held status beat keeps its value
    `FRPV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "status beat dropped or changed under stall")

    // Only the two status bits may be set
    `FRPV_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0, "status padding bits not zero")

    // A fresh status beat comes from a last or empty beat taken through the input register and then the status register
    `FRPV_ASSERT_NOW(a_out_cause, aclk, aresetn, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser[0]), 2), "status beat without a closing input beat")

endmodule

bind fat_relative_path_validator frpv_checker u_frpv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
